// ----- src/sotrs_pkg.sv -----
// Shared types and constants for the sorted offset table range search unit.
package sotrs_pkg;

    // Width of the match length register and of the item kind selector.
    localparam int ML_W     = 16;
    localparam int MODE_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    // Configuration register indexes.
    localparam logic [APB_AW-1:0] REG_MLEN = 2'd0;

    // Item kinds; the fourth code has no operation and falls to default arms.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_GET    = 2'd2
    } t_mode;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_FETCH,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic srch_init;   // load lo = 0, hi = count
        logic probe;       // read the entry at mid
        logic compare;     // narrow lo/hi from the read entry
        logic pass;        // 0: search for start, 1: search for end
        logic save_first;  // store lo as first index
        logic save_last;   // store lo as last index
        logic fetch;       // read the entry for a get
        logic finish;      // commit the item and load the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;       // kind of the item in work
        logic  count_zero; // table is empty
        logic  lo_lt_hi;   // search range not yet empty
        logic  out_free;   // output register can take a result
    } t_ctrl_sts;

endpackage

// ----- src/sotrs_ctrl.sv -----
// Controller state machine that sequences append, range search and get items.
module sotrs_ctrl
    import sotrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_mode     i_mode,
    output logic      o_in_ready,
    output t_ctrl_cmd o_cmd,
    input  t_ctrl_sts i_sts
);

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    // State and search pass registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_pass = 1'b0;
                    case (i_mode)
                        MODE_QUERY: begin
                            n_state = i_sts.count_zero ? ST_FINISH : ST_PROBE;
                        end
                        MODE_GET: begin
                            n_state = ST_FETCH;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (i_sts.lo_lt_hi) begin
                    n_state = ST_COMPARE;
                end else if (!r_pass) begin
                    n_pass = 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_COMPARE: begin
                n_state = ST_PROBE;
            end
            ST_FETCH: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands for the current state.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.srch_init = 1'b1;
                end
            end
            ST_PROBE: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.probe = 1'b1;
                end else if (!r_pass) begin
                    o_cmd.save_first = 1'b1;
                    o_cmd.srch_init  = 1'b1;
                end else begin
                    o_cmd.save_last = 1'b1;
                end
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // A compare step always follows the probe that read its entry.
    a_cmp_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COMPARE |-> $past(r_state) == ST_PROBE)
        else $error("compare step without a preceding probe");

    // Memory and commit commands never overlap.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.probe, o_cmd.compare, o_cmd.fetch, o_cmd.finish}))
        else $error("overlapping datapath commands");

    // The second search pass only runs on a query item.
    a_pass_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pass && r_state == ST_PROBE) |-> i_sts.mode == MODE_QUERY)
        else $error("end search on a non-query item");

endmodule

// ----- src/sotrs_dpath.sv -----
// Datapath: offset memory, entry count, search bounds and the result register.
module sotrs_dpath
    import sotrs_pkg::*;
#(
    parameter  int DEPTH       = 65536,
    parameter  int OFFSET_BITS = 48,
    localparam int IDX_W       = $clog2(DEPTH),
    localparam int CNT_W       = $clog2(DEPTH + 1)
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    output t_ctrl_sts              o_sts,
    input  t_mode                  i_mode,
    input  logic [OFFSET_BITS-1:0] i_offset_value,
    input  logic [OFFSET_BITS-1:0] i_offset_end,
    input  logic [IDX_W-1:0]       i_entry_index,
    input  logic [ML_W-1:0]        i_mlen,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [CNT_W-1:0]       o_first_index,
    output logic [CNT_W-1:0]       o_last_index,
    output logic [OFFSET_BITS-1:0] o_match_start,
    output logic [OFFSET_BITS:0]   o_match_end,
    output logic                   o_ok,
    output logic [CNT_W-1:0]       o_entries_held
);

    logic [OFFSET_BITS-1:0] r_mem [DEPTH];
    logic [OFFSET_BITS-1:0] r_rd_data;

    t_mode                  r_mode;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_end;
    logic [IDX_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_lo;
    logic [CNT_W-1:0]       r_hi;
    logic [CNT_W-1:0]       r_mid;
    logic [CNT_W-1:0]       r_first;
    logic [CNT_W-1:0]       r_last;

    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_out_first;
    logic [CNT_W-1:0]       r_out_last;
    logic [OFFSET_BITS-1:0] r_out_start;
    logic [OFFSET_BITS:0]   r_out_end;
    logic                   r_out_ok;
    logic [CNT_W-1:0]       r_out_held;

    logic [CNT_W-1:0]       w_mid;
    logic [OFFSET_BITS-1:0] w_target;
    logic                   w_less;
    logic                   w_full;
    logic                   w_get_valid;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;

    logic [CNT_W-1:0]       n_first;
    logic [CNT_W-1:0]       n_last;
    logic [OFFSET_BITS-1:0] n_start;
    logic [OFFSET_BITS:0]   n_end;
    logic                   n_ok;
    logic [CNT_W-1:0]       n_count;

    // Search arithmetic and table conditions.
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_target    = i_cmd.pass ? r_end : r_start;
    assign w_less      = r_rd_data < w_target;
    assign w_full      = r_count == CNT_W'(DEPTH);
    assign w_get_valid = CNT_W'(r_idx) < r_count;

    // One read port shared by search probes and gets; one write port for appends.
    assign w_rd_en   = i_cmd.probe || (i_cmd.fetch && w_get_valid);
    assign w_rd_addr = i_cmd.probe ? w_mid[IDX_W-1:0] : r_idx;
    assign w_wr_en   = i_cmd.finish && r_mode == MODE_APPEND && !w_full;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_start;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Captured item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_start <= i_offset_value;
            r_end   <= i_offset_end;
            r_idx   <= i_entry_index;
        end
    end

    // Search bounds, probe index and found indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.compare) begin
            if (w_less) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.capture) begin
            r_first <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.save_first) begin
                r_first <= r_lo;
            end
            if (i_cmd.save_last) begin
                r_last <= r_lo;
            end
        end
    end

    // Result fields by item kind.
    always_comb begin
        n_first = '0;
        n_last  = '0;
        n_start = '0;
        n_end   = '0;
        n_ok    = 1'b0;
        n_count = r_count;
        case (r_mode)
            MODE_APPEND: begin
                n_ok = !w_full;
                if (!w_full) begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_QUERY: begin
                n_first = r_first;
                n_last  = r_last;
            end
            MODE_GET: begin
                if (w_get_valid) begin
                    n_ok    = 1'b1;
                    n_start = r_rd_data;
                    n_end   = {1'b0, r_rd_data} + (OFFSET_BITS + 1)'(i_mlen);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_first <= n_first;
            r_out_last  <= n_last;
            r_out_start <= n_start;
            r_out_end   <= n_end;
            r_out_ok    <= n_ok;
            r_out_held  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_index  = r_out_first;
    assign o_last_index   = r_out_last;
    assign o_match_start  = r_out_start;
    assign o_match_end    = r_out_end;
    assign o_ok           = r_out_ok;
    assign o_entries_held = r_out_held;

    // Status to the controller.
    assign o_sts.mode       = r_mode;
    assign o_sts.count_zero = r_count == '0;
    assign o_sts.lo_lt_hi   = r_lo < r_hi;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // The search range never inverts.
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search lower bound above upper bound");

    // The count only grows by one, and only when an append commits.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |->
            $past(i_cmd.finish) && $past(r_mode) == MODE_APPEND
            && r_count == $past(r_count) + 1'b1)
        else $error("entry count changed outside an append");

endmodule

// ----- src/sorted_offset_table_range_search_unit.sv -----
// Top level of the sorted offset table range search unit: stream ports and register port.
//
// The unit keeps a table of up to DEPTH start offsets in a single-port-read,
// single-port-write memory with a registered read. Each input item is an append
// (tuser 0), a range query (tuser 1) or a get by index (tuser 2); it produces
// exactly one result item, and the unit works on one item at a time. An append
// or a mode-three item goes from acceptance straight to the finish state, a get
// through a fetch state first. A range query runs two lower-bound binary
// searches one after the other; each probe has an address step, then a compare
// step against the registered read data, and each search ends with one more
// probe step that finds its range empty. Each search makes at most
// ceil(log2(count + 1)) probes. The memory read port and its output register
// set the probe cost. A new item is accepted while the previous result still
// waits in the output register, and is held finished until that register is
// free. The match length is written through the register port at any address
// and reads back at address 0; the user writes it only while the unit is idle,
// which the unit itself does not enforce. The offset memory is not cleared at
// reset; only entries below the count are ever read.
module sorted_offset_table_range_search_unit
    import sotrs_pkg::*;
#(
    parameter  int DEPTH       = 65536,
    parameter  int OFFSET_BITS = 48,
    localparam int IDX_W       = $clog2(DEPTH),
    localparam int CNT_W       = $clog2(DEPTH + 1),
    localparam int IN_FIELDS_W = 2 * OFFSET_BITS + IDX_W,
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = 3 * CNT_W + 2 * OFFSET_BITS + 2,
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: offset_value, offset_end, entry_index (from bit 0 up), zero padded
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // Result items.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: first_index, last_index, match_start, match_end, ok, entries_held
    // (from bit 0 up), zero padded
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [ML_W-1:0]        r_mlen;
    t_ctrl_cmd              w_cmd;
    t_ctrl_sts              w_sts;
    t_mode                  w_mode;
    logic [CNT_W-1:0]       w_first_index;
    logic [CNT_W-1:0]       w_last_index;
    logic [OFFSET_BITS-1:0] w_match_start;
    logic [OFFSET_BITS:0]   w_match_end;
    logic                   w_ok;
    logic [CNT_W-1:0]       w_entries_held;

    // Register port: one register, written on the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlen <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_mlen <= pwdata[ML_W-1:0];
        end
    end

    always_comb begin
        case (paddr)
            REG_MLEN: prdata = APB_DW'(r_mlen);
            default:  prdata = '0;
        endcase
    end

    assign w_mode = t_mode'(s_axis_tuser);

    sotrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (w_mode),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    sotrs_dpath #(
        .DEPTH       (DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_mode         (w_mode),
        .i_offset_value (s_axis_tdata[OFFSET_BITS-1:0]),
        .i_offset_end   (s_axis_tdata[2*OFFSET_BITS-1:OFFSET_BITS]),
        .i_entry_index  (s_axis_tdata[IN_FIELDS_W-1:2*OFFSET_BITS]),
        .i_mlen         (r_mlen),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_first_index  (w_first_index),
        .o_last_index   (w_last_index),
        .o_match_start  (w_match_start),
        .o_match_end    (w_match_end),
        .o_ok           (w_ok),
        .o_entries_held (w_entries_held)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_axis_tdata = OUT_DATA_W'({w_entries_held, w_ok, w_match_end,
                                      w_match_start, w_last_index, w_first_index});

endmodule

// ----- verif/sotrs_checker.sv -----
// Checker for the sorted offset table unit: watches both streams and the register port.
`timescale 1ns / 100ps

module sotrs_checker
    import sotrs_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int OFFSET_BITS = 48,
    parameter int CNT_W       = 17,
    parameter int IN_DATA_W   = 112,
    parameter int OUT_DATA_W  = 152
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // Fields from bit 0 up: offset_value, offset_end, entry_index.
    input  logic [IN_DATA_W-1:0]  i_in_data,
    // Fields: mode.
    input  logic [MODE_W-1:0]     i_in_mode,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // Fields from bit 0 up: first_index, last_index, match_start, match_end, ok, entries_held.
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int F_LAST  = CNT_W;
    localparam int F_START = 2 * CNT_W;
    localparam int F_END   = F_START + OFFSET_BITS;
    localparam int F_OK    = F_END + OFFSET_BITS + 1;
    localparam int F_HELD  = F_OK + 1;

    // One predicted result item.
    typedef struct packed {
        logic [CNT_W-1:0]       first_pos;
        logic [CNT_W-1:0]       last_pos;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS:0]   stop;
        logic                   ok;
        logic [CNT_W-1:0]       held;
    } t_table_result;

    // Shadow copy of the offset table and the match length register.
    logic [OFFSET_BITS-1:0] offset_copy [DEPTH];
    logic [CNT_W-1:0]       held_count;
    logic [ML_W-1:0]        match_len;
    t_table_result          result_fifo [$];

    // Lower-bound search over the entries held, probing in the same order as a
    // plain binary search so that unsorted tables give the same answer.
    function automatic logic [CNT_W-1:0] probe_search(input logic [OFFSET_BITS-1:0] target);
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] mid;
        lo = '0;
        hi = held_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (offset_copy[mid[IDX_W-1:0]] < target) begin
                lo = mid + 1'b1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one input item to the shadow table and returns its result.
    function automatic t_table_result apply_item(input logic [MODE_W-1:0] mode,
                                                 input logic [OFFSET_BITS-1:0] start_off,
                                                 input logic [OFFSET_BITS-1:0] end_off,
                                                 input logic [IDX_W-1:0] idx);
        t_table_result r;
        r = '0;
        case (mode)
            MODE_APPEND: begin
                // A full table drops the offset.
                if (held_count < CNT_W'(DEPTH)) begin
                    offset_copy[held_count[IDX_W-1:0]] = start_off;
                    held_count = held_count + 1'b1;
                    r.ok = 1'b1;
                end
            end
            MODE_QUERY: begin
                if (held_count != '0) begin
                    r.first_pos = probe_search(start_off);
                    r.last_pos  = probe_search(end_off);
                end
            end
            MODE_GET: begin
                if (CNT_W'(idx) < held_count) begin
                    r.start = offset_copy[idx];
                    r.stop  = {1'b0, r.start} + (OFFSET_BITS + 1)'(match_len);
                    r.ok    = 1'b1;
                end
            end
            default: ;
        endcase
        r.held = held_count;
        return r;
    endfunction

    function automatic int field_mismatch(input string fname, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track register writes, compare result items, predict accepted input items.
    always @(posedge i_clk) begin
        t_table_result want;
        int errs;
        int delta;
        errs  = 0;
        delta = 0;
        if (!i_rst_n) begin
            held_count = '0;
            match_len  = '0;
            result_fifo.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_MLEN) begin
                match_len = i_pwdata[ML_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (result_fifo.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    errs++;
                end else begin
                    want = result_fifo.pop_front();
                    delta--;
                    errs += field_mismatch("first_index", 64'(want.first_pos),
                                           64'(i_out_data[0 +: CNT_W]));
                    errs += field_mismatch("last_index", 64'(want.last_pos),
                                           64'(i_out_data[F_LAST +: CNT_W]));
                    errs += field_mismatch("match_start", 64'(want.start),
                                           64'(i_out_data[F_START +: OFFSET_BITS]));
                    errs += field_mismatch("match_end", 64'(want.stop),
                                           64'(i_out_data[F_END +: OFFSET_BITS + 1]));
                    errs += field_mismatch("ok", 64'(want.ok), 64'(i_out_data[F_OK]));
                    errs += field_mismatch("entries_held", 64'(want.held),
                                           64'(i_out_data[F_HELD +: CNT_W]));
                end
            end
            if (i_in_valid && i_in_ready) begin
                result_fifo.push_back(apply_item(i_in_mode,
                                                 i_in_data[0 +: OFFSET_BITS],
                                                 i_in_data[OFFSET_BITS +: OFFSET_BITS],
                                                 i_in_data[2 * OFFSET_BITS +: IDX_W]));
                delta++;
            end
            o_pending    <= o_pending + delta;
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ----- verif/sorted_offset_table_range_search_unit_tb.sv -----
// Testbench top for the sorted offset table unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sorted_offset_table_range_search_unit_tb
    import sotrs_pkg::*;
;

    localparam int DEPTH        = 65536;
    localparam int OFFSET_BITS  = 48;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IN_FIELDS_W  = 2 * OFFSET_BITS + IDX_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * CNT_W + 2 * OFFSET_BITS + 2;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 240;

    localparam logic [MODE_W-1:0]      MODE_UNUSED = 2'd3;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX  = '1;
    localparam logic [IDX_W-1:0]       INDEX_MAX   = '1;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_AW-1:0]     paddr   = '0;
    logic [APB_DW-1:0]     pwdata  = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int quiet_cycles = 0;
    int rx_hold      = 0;
    bit rx_idle_on   = 1'b0;
    bit tx_idle_on   = 1'b0;

    // Stimulus-side record of what was appended, used to aim queries and gets.
    logic [OFFSET_BITS-1:0] appended [DEPTH];
    int                     held_shadow = 0;
    logic [OFFSET_BITS-1:0] running_offset = '0;

    sorted_offset_table_range_search_unit #(
        .DEPTH       (DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sotrs_checker #(
        .DEPTH       (DEPTH),
        .OFFSET_BITS (OFFSET_BITS),
        .CNT_W       (CNT_W),
        .IN_DATA_W   (IN_DATA_W),
        .OUT_DATA_W  (OUT_DATA_W)
    ) table_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: ready drops at random while stalling is on.
    always @(posedge i_clk) begin
        if (!rx_idle_on) begin
            m_axis_tready <= 1'b1;
            rx_hold       <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (m_axis_tready) begin
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                rx_hold       <= $urandom_range(0, 15);
            end
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold       <= $urandom_range(0, 15);
        end
    end

    // Watchdog on cycles with no item accepted on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [OFFSET_BITS-1:0] rand_offset();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Advances the running offset by a step, saturating at the largest offset.
    function automatic logic [OFFSET_BITS-1:0] bump_running(input logic [31:0] step);
        logic [OFFSET_BITS:0] sum;
        sum = {1'b0, running_offset} + (OFFSET_BITS + 1)'(step);
        running_offset = sum[OFFSET_BITS] ? OFFSET_MAX : sum[OFFSET_BITS-1:0];
        return running_offset;
    endfunction

    // A stored offset or one next to it; a random offset while nothing is stored.
    function automatic logic [OFFSET_BITS-1:0] near_stored();
        logic [OFFSET_BITS-1:0] v;
        if (held_shadow == 0) begin
            return rand_offset();
        end
        v = appended[$urandom_range(0, held_shadow - 1)];
        case ($urandom_range(0, 2))
            0:       v = v - 1'b1;
            1:       v = v + 1'b1;
            default: ;
        endcase
        return v;
    endfunction

    // Presents one input item and holds it until it is accepted.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [OFFSET_BITS-1:0] start_off,
                             input logic [OFFSET_BITS-1:0] end_off,
                             input logic [IDX_W-1:0] idx);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[0 +: OFFSET_BITS]           = start_off;
        word[OFFSET_BITS +: OFFSET_BITS] = end_off;
        word[2 * OFFSET_BITS +: IDX_W]   = idx;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_APPEND && held_shadow < DEPTH) begin
            appended[held_shadow] = start_off;
            held_shadow++;
        end
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random item: mostly sorted appends and queries aimed at stored offsets.
    task automatic send_random_item();
        int                     pick;
        logic [OFFSET_BITS-1:0] a;
        logic [OFFSET_BITS-1:0] b;
        logic [OFFSET_BITS-1:0] t;
        logic [IDX_W-1:0]       idx;
        logic [31:0]            step;
        pick = $urandom_range(0, 99);
        a    = rand_offset();
        b    = rand_offset();
        idx  = rand_index();
        if (pick < 40) begin
            if ($urandom_range(0, 9) != 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: step = $urandom_range(0, 255);
                    7, 8:                step = $urandom_range(0, 1 << 20);
                    default:             step = $urandom;
                endcase
                a = bump_running(step);
            end else if ($urandom_range(0, 1) == 0) begin
                // Out-of-order append below the running offset.
                a = running_offset >> $urandom_range(1, 8);
            end
            send_item(MODE_APPEND, a, b, idx);
        end else if (pick < 72) begin
            case ($urandom_range(0, 4))
                0: ;
                1: a = near_stored();
                default: begin
                    a = near_stored();
                    b = near_stored();
                    if (b < a && $urandom_range(0, 3) != 0) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
            endcase
            send_item(MODE_QUERY, a, b, idx);
        end else if (pick < 95) begin
            case ($urandom_range(0, 5))
                0: ;
                1: idx = (held_shadow < DEPTH) ? IDX_W'(held_shadow) : idx;
                default: begin
                    if (held_shadow > 0) begin
                        idx = IDX_W'($urandom_range(0, held_shadow - 1));
                    end
                end
            endcase
            send_item(MODE_GET, a, b, idx);
        end else begin
            send_item(MODE_UNUSED, a, b, idx);
        end
    endtask

    initial begin
        logic [ML_W-1:0] ml_plan [4];

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_MLEN, $urandom_range(1, 16'hFFFE));
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        // Directed: empty table, duplicates, an out-of-order append, field extremes.
        send_item(MODE_QUERY, rand_offset(), rand_offset(), rand_index());
        send_item(MODE_GET, rand_offset(), rand_offset(), '0);
        send_item(MODE_UNUSED, rand_offset(), rand_offset(), rand_index());
        send_item(MODE_APPEND, '0, rand_offset(), rand_index());
        send_item(MODE_APPEND, '0, rand_offset(), rand_index());
        send_item(MODE_APPEND, 48'd10, rand_offset(), rand_index());
        send_item(MODE_APPEND, 48'd5, rand_offset(), rand_index());
        send_item(MODE_APPEND, 48'd20, OFFSET_MAX, INDEX_MAX);
        send_item(MODE_QUERY, '0, OFFSET_MAX, rand_index());
        send_item(MODE_QUERY, 48'd10, 48'd10, rand_index());
        send_item(MODE_QUERY, OFFSET_MAX, '0, rand_index());
        send_item(MODE_QUERY, 48'd6, 48'd11, rand_index());
        send_item(MODE_QUERY, 48'd21, '0, '0);
        send_item(MODE_GET, rand_offset(), rand_offset(), '0);
        send_item(MODE_GET, rand_offset(), rand_offset(), 16'd4);
        send_item(MODE_GET, rand_offset(), rand_offset(), 16'd5);
        send_item(MODE_GET, OFFSET_MAX, OFFSET_MAX, INDEX_MAX);
        send_item(MODE_UNUSED, OFFSET_MAX, OFFSET_MAX, INDEX_MAX);
        send_item(MODE_APPEND, 48'd20, rand_offset(), rand_index());
        running_offset = 48'd20;

        // Random phases, each under its own match length.
        ml_plan[0] = '1;
        ml_plan[1] = '0;
        ml_plan[2] = ML_W'($urandom_range(1, 16'hFFFE));
        ml_plan[3] = 16'd1;
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            write_reg(REG_MLEN, ml_plan[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on <= ($urandom_range(0, 3) != 0);
                end
                send_random_item();
            end
        end

        // Last part without idling: largest offsets, gets at both ends, wide searches.
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        drain_results();
        write_reg(REG_MLEN, '1);
        send_item(MODE_APPEND, OFFSET_MAX, rand_offset(), rand_index());
        send_item(MODE_APPEND, OFFSET_MAX, rand_offset(), rand_index());
        send_item(MODE_GET, rand_offset(), rand_offset(), IDX_W'(held_shadow - 1));
        send_item(MODE_GET, rand_offset(), rand_offset(), IDX_W'(held_shadow));
        send_item(MODE_GET, rand_offset(), rand_offset(), INDEX_MAX);
        send_item(MODE_GET, rand_offset(), rand_offset(), '0);
        send_item(MODE_QUERY, '0, OFFSET_MAX, rand_index());
        send_item(MODE_QUERY, OFFSET_MAX, OFFSET_MAX, rand_index());
        send_item(MODE_QUERY, OFFSET_MAX, '0, rand_index());
        send_item(MODE_UNUSED, rand_offset(), rand_offset(), rand_index());
        for (int n = 0; n < 20; n++) begin
            send_random_item();
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/sotrs_pkg.sv
src/sotrs_ctrl.sv
src/sotrs_dpath.sv
src/sorted_offset_table_range_search_unit.sv
verif/sotrs_checker.sv
verif/sorted_offset_table_range_search_unit_tb.sv
